### rtl/plob_pkg.sv
// shared constants, status codes and cell control type for the price level book
// depends on nothing
`timescale 1ns / 1ps

package plob_pkg;

	localparam int LEVELS  = 64;
	localparam int PRICE_W = 32;
	localparam int QTY_W   = 48;
	localparam int CNT_W   = $clog2(LEVELS + 1);

	typedef enum logic [2:0] {
		ST_REPLACED = 3'd0,
		ST_INSERTED = 3'd1,
		ST_REMOVED  = 3'd2,
		ST_IGNORED  = 3'd3,
		ST_DROPPED  = 3'd4,
		ST_NOT_KEPT = 3'd5
	} status_t;

	typedef struct packed {
		logic remove;
		logic replace;
		logic insert;
	} cell_ctrl_t;

endpackage

### rtl/plob_cell.sv
// one price level of one side, with compare against the incoming item and neighbor shift
// depends on plob_pkg
`timescale 1ns / 1ps

module plob_cell (
	input  logic                         clk,
	input  logic                         bid,
	input  logic                         valid,
	input  logic [plob_pkg::PRICE_W-1:0] item_price,
	input  logic [plob_pkg::QTY_W-1:0]   item_qty,
	input  plob_pkg::cell_ctrl_t         ctrl,
	input  logic                         ge_left,
	input  logic [plob_pkg::PRICE_W-1:0] left_price,
	input  logic [plob_pkg::QTY_W-1:0]   left_qty,
	input  logic [plob_pkg::PRICE_W-1:0] right_price,
	input  logic [plob_pkg::QTY_W-1:0]   right_qty,
	output logic                         ge,
	output logic                         at_pos,
	output logic                         match,
	output logic [plob_pkg::PRICE_W-1:0] price,
	output logic [plob_pkg::QTY_W-1:0]   qty
);

	logic [plob_pkg::PRICE_W-1:0] price_q;
	logic [plob_pkg::QTY_W-1:0]   qty_q;
	logic                         worse;

	// incoming price ranks strictly worse than this level
	assign worse  = valid && (bid ? (item_price < price_q) : (item_price > price_q));
	assign ge     = !worse;
	assign at_pos = ge && !ge_left;
	assign match  = valid && (item_price == price_q);
	assign price  = price_q;
	assign qty    = qty_q;

	always_ff @(posedge clk) begin
		priority if (ctrl.remove && ge) begin
			price_q <= right_price;
			qty_q   <= right_qty;
		end else if (ctrl.replace && at_pos) begin
			qty_q <= item_qty;
		end else if (ctrl.insert && at_pos) begin
			price_q <= item_price;
			qty_q   <= item_qty;
		end else if (ctrl.insert && ge_left) begin
			price_q <= left_price;
			qty_q   <= left_qty;
		end else begin
			price_q <= price_q;
			qty_q   <= qty_q;
		end
	end

endmodule

### rtl/plob_side.sv
// one side of the book: a row of level cells, its count and the update decision
// depends on plob_pkg and plob_cell
`timescale 1ns / 1ps

module plob_side (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         bid,
	input  logic                         go,
	input  logic                         clr,
	input  logic [plob_pkg::PRICE_W-1:0] item_price,
	input  logic [plob_pkg::QTY_W-1:0]   item_qty,
	output plob_pkg::status_t            status,
	output logic [plob_pkg::CNT_W-1:0]   position,
	output logic [plob_pkg::CNT_W-1:0]   levels,
	output logic [plob_pkg::PRICE_W-1:0] best_price,
	output logic [plob_pkg::QTY_W-1:0]   best_qty
);

	localparam int N = plob_pkg::LEVELS;

	logic [plob_pkg::CNT_W-1:0]   count_q;
	logic [plob_pkg::CNT_W-1:0]   n_eff;
	logic [plob_pkg::CNT_W-1:0]   n_next;
	logic [N-1:0]                 ge;
	logic [N-1:0]                 at_pos;
	logic [N-1:0]                 match;
	logic [plob_pkg::PRICE_W-1:0] cprice [N];
	logic [plob_pkg::QTY_W-1:0]   cqty   [N];
	logic                         any_match;
	logic                         found;
	logic                         qty_zero;
	logic [plob_pkg::CNT_W-1:0]   idx;
	plob_pkg::cell_ctrl_t         ctrl;

	assign n_eff = clr ? '0 : count_q;

	for (genvar k = 0; k < N; k++) begin : g_cell
		logic                         v;
		logic                         gl;
		logic [plob_pkg::PRICE_W-1:0] lp;
		logic [plob_pkg::QTY_W-1:0]   lq;
		logic [plob_pkg::PRICE_W-1:0] rp;
		logic [plob_pkg::QTY_W-1:0]   rq;

		assign v = plob_pkg::CNT_W'(k) < n_eff;
		if (k == 0) begin : g_first
			assign gl = 1'b0;
			assign lp = cprice[k];
			assign lq = cqty[k];
		end else begin : g_mid
			assign gl = ge[k-1];
			assign lp = cprice[k-1];
			assign lq = cqty[k-1];
		end
		if (k == N - 1) begin : g_last
			assign rp = cprice[k];
			assign rq = cqty[k];
		end else begin : g_next
			assign rp = cprice[k+1];
			assign rq = cqty[k+1];
		end

		plob_cell u_cell (
			.clk         (clk),
			.bid         (bid),
			.valid       (v),
			.item_price  (item_price),
			.item_qty    (item_qty),
			.ctrl        (ctrl),
			.ge_left     (gl),
			.left_price  (lp),
			.left_qty    (lq),
			.right_price (rp),
			.right_qty   (rq),
			.ge          (ge[k]),
			.at_pos      (at_pos[k]),
			.match       (match[k]),
			.price       (cprice[k]),
			.qty         (cqty[k])
		);
	end

	// position is one-hot over the cells, so an or of indexes encodes it
	always_comb begin
		idx = '0;
		for (int k = 0; k < N; k++) begin
			if (at_pos[k]) idx = idx | plob_pkg::CNT_W'(k);
		end
	end

	assign any_match = |match;
	assign found     = |at_pos;
	assign qty_zero  = (item_qty == '0);

	always_comb begin
		ctrl     = '0;
		n_next   = n_eff;
		position = plob_pkg::CNT_W'(N);
		status   = plob_pkg::ST_NOT_KEPT;
		priority if (any_match && qty_zero) begin
			ctrl.remove = go;
			n_next      = n_eff - plob_pkg::CNT_W'(1);
			position    = idx;
			status      = plob_pkg::ST_REMOVED;
		end else if (any_match) begin
			ctrl.replace = go;
			position     = idx;
			status       = plob_pkg::ST_REPLACED;
		end else if (qty_zero) begin
			status = plob_pkg::ST_IGNORED;
		end else if (found) begin
			ctrl.insert = go;
			position    = idx;
			if (n_eff < plob_pkg::CNT_W'(N)) begin
				n_next = n_eff + plob_pkg::CNT_W'(1);
				status = plob_pkg::ST_INSERTED;
			end else begin
				status = plob_pkg::ST_DROPPED;
			end
		end else begin
			// full side and the price ranks below the worst level
			status = plob_pkg::ST_NOT_KEPT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (go) begin
			count_q <= n_next;
		end else if (clr) begin
			count_q <= '0;
		end
	end

	assign levels     = count_q;
	assign best_price = (count_q != '0) ? cprice[0] : '0;
	assign best_qty   = (count_q != '0) ? cqty[0] : '0;

endmodule

### rtl/price_level_order_book.sv
// top level of the price level order book: item register, sequencer, result register
// depends on plob_pkg and plob_side
`timescale 1ns / 1ps

//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------------
//  in      | in_valid / in_stall  | restart, side, price, quantity
//  out     | out_valid / out_stall| status, position, best_ask_*, best_bid_*, *_levels
//
// the transfer edge loads the item register; once the result slot is free, the update
// compares it against every level cell of the chosen side at once and shifts the row
// while the result waits on out_stall the next item may already transfer in; its
// update is held until the waiting result is taken
// reset clears both level counts and all handshake state; level contents are left as is

module price_level_order_book (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         restart,
	input  logic                         side,
	input  logic [plob_pkg::PRICE_W-1:0] price,
	input  logic [plob_pkg::QTY_W-1:0]   quantity,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [2:0]                   status,
	output logic [plob_pkg::CNT_W-1:0]   position,
	output logic [plob_pkg::PRICE_W-1:0] best_ask_price,
	output logic [plob_pkg::QTY_W-1:0]   best_ask_quantity,
	output logic [plob_pkg::PRICE_W-1:0] best_bid_price,
	output logic [plob_pkg::QTY_W-1:0]   best_bid_quantity,
	output logic [plob_pkg::CNT_W-1:0]   ask_levels,
	output logic [plob_pkg::CNT_W-1:0]   bid_levels
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t                       state_q;
	logic                         restart_q;
	logic                         side_q;
	logic [plob_pkg::PRICE_W-1:0] price_q;
	logic [plob_pkg::QTY_W-1:0]   qty_q;
	logic                         out_valid_q;
	plob_pkg::status_t            status_q;
	logic [plob_pkg::CNT_W-1:0]   position_q;
	logic                         res_side_q;

	logic                         in_xfer;
	logic                         out_xfer;
	logic                         exec;
	plob_pkg::status_t            ask_status;
	plob_pkg::status_t            bid_status;
	logic [plob_pkg::CNT_W-1:0]   ask_pos;
	logic [plob_pkg::CNT_W-1:0]   bid_pos;

	assign in_stall = (state_q != S_IDLE);
	assign in_xfer  = in_valid && !in_stall;
	assign out_xfer = out_valid_q && !out_stall;
	// the row update lands together with its result, so the result slot must be free
	assign exec     = (state_q == S_EXEC) && (!out_valid_q || !out_stall);

	// item register
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			restart_q <= restart;
			side_q    <= side;
			price_q   <= price;
			qty_q     <= quantity;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (exec) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// ask row
	plob_side u_ask (
		.clk        (clk),
		.arst_n     (arst_n),
		.bid        (1'b0),
		.go         (exec && !side_q),
		.clr        (exec && restart_q),
		.item_price (price_q),
		.item_qty   (qty_q),
		.status     (ask_status),
		.position   (ask_pos),
		.levels     (ask_levels),
		.best_price (best_ask_price),
		.best_qty   (best_ask_quantity)
	);

	// bid row
	plob_side u_bid (
		.clk        (clk),
		.arst_n     (arst_n),
		.bid        (1'b1),
		.go         (exec && side_q),
		.clr        (exec && restart_q),
		.item_price (price_q),
		.item_qty   (qty_q),
		.status     (bid_status),
		.position   (bid_pos),
		.levels     (bid_levels),
		.best_price (best_bid_price),
		.best_qty   (best_bid_quantity)
	);

	// result register; best levels and counts come straight from the rows, which
	// only move on an update, and an update only happens once the slot is free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exec) begin
			out_valid_q <= 1'b1;
		end else if (out_xfer) begin
			out_valid_q <= 1'b0;
		end
	end

	// status, position and side of the held result; side_q may already belong to the next item
	always_ff @(posedge clk) begin
		if (exec) begin
			status_q   <= side_q ? bid_status : ask_status;
			position_q <= side_q ? bid_pos : ask_pos;
			res_side_q <= side_q;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign position  = position_q;

	// level counts never exceed the row length
	a_levels_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(ask_levels <= plob_pkg::CNT_W'(plob_pkg::LEVELS)) &&
		(bid_levels <= plob_pkg::CNT_W'(plob_pkg::LEVELS)))
		else $error("level count beyond row length");

	// counts only move on a row update
	a_levels_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!exec |=> $stable(ask_levels) && $stable(bid_levels))
		else $error("level count moved without an update");

	// ignored and not kept items report the out-of-row position
	a_pos_none: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (status_q == plob_pkg::ST_IGNORED ||
		status_q == plob_pkg::ST_NOT_KEPT) |->
		position_q == plob_pkg::CNT_W'(plob_pkg::LEVELS))
		else $error("position on an untouched item");

	// a plain insert lands inside the grown side
	a_insert_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q == plob_pkg::ST_INSERTED |->
		position_q < (res_side_q ? bid_levels : ask_levels))
		else $error("insert position outside the side");

endmodule

### tb/tb_price_level_order_book.sv
// self-checking bench for price_level_order_book: directed, full-book and random level updates
// depends on plob_pkg and the price_level_order_book rtl; keeps its own copy of both book sides
`timescale 1ns / 1ps

module tb_price_level_order_book;

	// centre of the random price band; asks sit above, bids below
	localparam int unsigned ASK_FLOOR = 50_000;
	localparam int unsigned BID_TOP   = 49_999;
	localparam int unsigned BAND      = 3_000;
	localparam int          SIDE_ASK  = 0;
	localparam int          SIDE_BID  = 1;

	typedef struct {
		plob_pkg::status_t              st;
		logic [plob_pkg::CNT_W-1:0]     pos;
		logic [plob_pkg::PRICE_W-1:0]   ask_px;
		logic [plob_pkg::QTY_W-1:0]     ask_qty;
		logic [plob_pkg::PRICE_W-1:0]   bid_px;
		logic [plob_pkg::QTY_W-1:0]     bid_qty;
		logic [plob_pkg::CNT_W-1:0]     ask_n;
		logic [plob_pkg::CNT_W-1:0]     bid_n;
	} book_result_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           in_valid = 1'b0;
	logic                           in_stall;
	logic                           restart = 1'b0;
	logic                           side = 1'b0;
	logic [plob_pkg::PRICE_W-1:0]   price = '0;
	logic [plob_pkg::QTY_W-1:0]     quantity = '0;
	logic                           out_valid;
	logic                           out_stall = 1'b0;
	logic [2:0]                     status;
	logic [plob_pkg::CNT_W-1:0]     position;
	logic [plob_pkg::PRICE_W-1:0]   best_ask_price;
	logic [plob_pkg::QTY_W-1:0]     best_ask_quantity;
	logic [plob_pkg::PRICE_W-1:0]   best_bid_price;
	logic [plob_pkg::QTY_W-1:0]     best_bid_quantity;
	logic [plob_pkg::CNT_W-1:0]     ask_levels;
	logic [plob_pkg::CNT_W-1:0]     bid_levels;

	// shadow book: index 0 of each side is the best level
	logic [plob_pkg::PRICE_W-1:0]   book_px  [2][plob_pkg::LEVELS];
	logic [plob_pkg::QTY_W-1:0]     book_qty [2][plob_pkg::LEVELS];
	int                             book_n   [2];

	book_result_t         pending_results[$];
	int                   src_idle_pct = 0;
	int                   sink_stall_pct = 0;
	int                   mismatches = 0;
	int                   level_updates = 0;
	int                   results_checked = 0;
	int                   status_seen [6];

	always #1 clk = ~clk;

	price_level_order_book u_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.restart           (restart),
		.side              (side),
		.price             (price),
		.quantity          (quantity),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.status            (status),
		.position          (position),
		.best_ask_price    (best_ask_price),
		.best_ask_quantity (best_ask_quantity),
		.best_bid_price    (best_bid_price),
		.best_bid_quantity (best_bid_quantity),
		.ask_levels        (ask_levels),
		.bid_levels        (bid_levels)
	);

	// applies one level update to the shadow book and returns the result it should produce
	function automatic book_result_t apply_level(input logic rs, input logic sd_bit,
			input logic [plob_pkg::PRICE_W-1:0] px, input logic [plob_pkg::QTY_W-1:0] qty);
		book_result_t res;
		int sd, n, i, k, top;
		sd = sd_bit ? SIDE_BID : SIDE_ASK;
		if (rs) begin
			book_n[SIDE_ASK] = 0;
			book_n[SIDE_BID] = 0;
		end
		n = book_n[sd];
		// walk past every level that ranks strictly better than the new price
		i = 0;
		while (i < n && (sd == SIDE_BID ? px < book_px[sd][i] : px > book_px[sd][i]))
			i++;
		if (i < n && book_px[sd][i] == px) begin
			if (qty == '0) begin
				for (k = i; k + 1 < n; k++) begin
					book_px[sd][k]  = book_px[sd][k + 1];
					book_qty[sd][k] = book_qty[sd][k + 1];
				end
				n--;
				res.st = plob_pkg::ST_REMOVED;
			end else begin
				book_qty[sd][i] = qty;
				res.st = plob_pkg::ST_REPLACED;
			end
			res.pos = plob_pkg::CNT_W'(i);
		end else if (qty == '0) begin
			res.st  = plob_pkg::ST_IGNORED;
			res.pos = plob_pkg::CNT_W'(plob_pkg::LEVELS);
		end else if (i >= plob_pkg::LEVELS) begin
			// full side and the price ranks below the worst level
			res.st  = plob_pkg::ST_NOT_KEPT;
			res.pos = plob_pkg::CNT_W'(plob_pkg::LEVELS);
		end else begin
			// on a full side the shift pushes the worst level out
			top = (n < plob_pkg::LEVELS) ? n : plob_pkg::LEVELS - 1;
			res.st = (n < plob_pkg::LEVELS) ? plob_pkg::ST_INSERTED : plob_pkg::ST_DROPPED;
			for (k = top; k > i; k--) begin
				book_px[sd][k]  = book_px[sd][k - 1];
				book_qty[sd][k] = book_qty[sd][k - 1];
			end
			book_px[sd][i]  = px;
			book_qty[sd][i] = qty;
			if (n < plob_pkg::LEVELS)
				n++;
			res.pos = plob_pkg::CNT_W'(i);
		end
		book_n[sd] = n;
		res.ask_px  = book_n[SIDE_ASK] > 0 ? book_px[SIDE_ASK][0] : '0;
		res.ask_qty = book_n[SIDE_ASK] > 0 ? book_qty[SIDE_ASK][0] : '0;
		res.bid_px  = book_n[SIDE_BID] > 0 ? book_px[SIDE_BID][0] : '0;
		res.bid_qty = book_n[SIDE_BID] > 0 ? book_qty[SIDE_BID][0] : '0;
		res.ask_n   = plob_pkg::CNT_W'(book_n[SIDE_ASK]);
		res.bid_n   = plob_pkg::CNT_W'(book_n[SIDE_BID]);
		status_seen[res.st]++;
		return res;
	endfunction

	// nonzero size, mostly full width, sometimes small lots
	function automatic logic [plob_pkg::QTY_W-1:0] rand_qty();
		logic [63:0] r;
		r = {$urandom, $urandom};
		if ($urandom_range(0, 3) == 0)
			r = 64'($urandom_range(1, 1000));
		if (r[plob_pkg::QTY_W-1:0] == '0)
			r = 64'd1;
		return r[plob_pkg::QTY_W-1:0];
	endfunction

	// a price in the busy band of the given side
	function automatic logic [plob_pkg::PRICE_W-1:0] near_price(input bit sd);
		if (sd)
			return plob_pkg::PRICE_W'(BID_TOP - $urandom_range(0, BAND - 1));
		return plob_pkg::PRICE_W'(ASK_FLOOR + $urandom_range(0, BAND - 1));
	endfunction

	// a price already held on the side; caller makes sure the side is not empty
	function automatic logic [plob_pkg::PRICE_W-1:0] held_price(input bit sd);
		return book_px[sd][$urandom_range(0, book_n[sd] - 1)];
	endfunction

	// one transfer on the input channel, with random idle cycles ahead of it
	task automatic send_level(input logic rs, input logic sd,
			input logic [plob_pkg::PRICE_W-1:0] px, input logic [plob_pkg::QTY_W-1:0] qty);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		restart  <= rs;
		side     <= sd;
		price    <= px;
		quantity <= qty;
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
		// transfer took place at this edge
		pending_results.push_back(apply_level(rs, sd, px, qty));
		level_updates++;
	endtask

	function automatic void cmp_field(input string name, input logic [63:0] exp_v,
			input logic [63:0] act_v);
		if (act_v !== exp_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, act_v);
			mismatches++;
		end
	endfunction

	// result side: random stall, and every accepted result checked against the oldest prediction
	always @(posedge clk) begin
		book_result_t want;
		if (arst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
			if (pending_results.size() == 0) begin
				$error("result with status %0d arrived with nothing outstanding", status);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				cmp_field("status", 64'(want.st), 64'(status));
				cmp_field("position", 64'(want.pos), 64'(position));
				cmp_field("best_ask_price", 64'(want.ask_px), 64'(best_ask_price));
				cmp_field("best_ask_quantity", 64'(want.ask_qty), 64'(best_ask_quantity));
				cmp_field("best_bid_price", 64'(want.bid_px), 64'(best_bid_price));
				cmp_field("best_bid_quantity", 64'(want.bid_qty), 64'(best_bid_quantity));
				cmp_field("ask_levels", 64'(want.ask_n), 64'(ask_levels));
				cmp_field("bid_levels", 64'(want.bid_n), 64'(bid_levels));
				results_checked++;
			end
		end
		out_stall <= ($urandom_range(0, 99) < sink_stall_pct);
	end

	// hand-picked updates: insert, replace, remove and ignore, empty sides, restart, extreme prices and sizes
	task automatic test_basic_updates();
		send_level(1'b1, 1'b0, 32'd1000, 48'd5);                    // insert on empty ask side
		send_level(1'b0, 1'b1, 32'd900, 48'hFFFF_FFFF_FFFF);         // insert on empty bid side
		send_level(1'b0, 1'b0, 32'd1000, 48'd7);                    // replace best ask
		send_level(1'b0, 1'b0, 32'd990, 48'd3);                     // new best ask
		send_level(1'b0, 1'b0, 32'd1010, 48'd4);                    // insert behind
		send_level(1'b0, 1'b0, 32'hFFFF_FFFF, 48'd1);               // append at the tail
		send_level(1'b0, 1'b1, 32'd0, 48'd1);                       // lowest bid at the tail
		send_level(1'b0, 1'b1, 32'hFFFF_FFFF, 48'd2);               // highest bid at the head
		send_level(1'b0, 1'b0, 32'd1000, 48'd0);                    // remove in the middle
		send_level(1'b0, 1'b0, 32'hFFFF_FFFF, 48'd0);               // remove the tail
		send_level(1'b0, 1'b1, 32'hFFFF_FFFF, 48'd0);               // remove the head
		send_level(1'b0, 1'b0, 32'd1005, 48'd0);                    // zero size, absent price
		send_level(1'b1, 1'b1, 32'd900, 48'd0);                     // restart carrying zero size
		send_level(1'b0, 1'b0, 32'd700, 48'd0);                     // zero size on empty side
		send_level(1'b0, 1'b0, 32'd0, 48'hFFFF_FFFF_FFFF);           // lowest price, biggest size
		send_level(1'b0, 1'b1, 32'hAAAA_5555, 48'h5555_AAAA_5555);
		send_level(1'b0, 1'b1, 32'h5555_AAAA, 48'hAAAA_5555_AAAA);
		send_level(1'b0, 1'b0, 32'd0, 48'd0);                       // empties the ask side
		send_level(1'b0, 1'b1, 32'h5555_AAAA, 48'd0);               // remove last bid
		send_level(1'b0, 1'b1, 32'hAAAA_5555, 48'd1);               // replace the only bid
		send_level(1'b1, 1'b0, 32'd1234, 48'd9);                    // restart with a real level
	endtask

	// fills a side to LEVELS and works its edges: drop at head and tail, not kept, replace, remove
	task automatic fill_and_push(input bit sd, input logic rs);
		logic [plob_pkg::PRICE_W-1:0] worst, best;
		int j;
		send_level(rs, sd, near_price(sd), rand_qty());
		while (book_n[sd] < plob_pkg::LEVELS)
			send_level(1'b0, sd, near_price(sd), rand_qty());
		worst = book_px[sd][plob_pkg::LEVELS - 1];
		best  = book_px[sd][0];
		send_level(1'b0, sd, sd ? worst - 1 : worst + 1, rand_qty());   // beyond the worst
		send_level(1'b0, sd, sd ? best + 1 : best - 1, rand_qty());     // better than best
		// replace at the tail
		send_level(1'b0, sd, book_px[sd][plob_pkg::LEVELS - 1], rand_qty());
		// squeeze in just ahead of the worst level when there is room
		worst = book_px[sd][plob_pkg::LEVELS - 1];
		if (sd ? worst + 1 < book_px[sd][plob_pkg::LEVELS - 2] :
				worst - 1 > book_px[sd][plob_pkg::LEVELS - 2])
			send_level(1'b0, sd, sd ? worst + 1 : worst - 1, rand_qty());
		// remove the tail
		send_level(1'b0, sd, book_px[sd][plob_pkg::LEVELS - 1], 48'd0);
		send_level(1'b0, sd, near_price(sd), rand_qty());
		for (j = 0; j < 30; j++)
			send_level(1'b0, sd, near_price(sd), $urandom_range(0, 5) == 0 ? 48'd0 : rand_qty());
	endtask

	task automatic test_full_book();
		fill_and_push(1'b0, 1'b1);
		fill_and_push(1'b1, 1'b0);
	endtask

	// mixed traffic: snapshots after restart, then replaces, removes, inserts and noise
	task automatic test_random_traffic(input int n_items);
		int sent, pick, snap, k;
		bit sd;
		sent = 0;
		while (sent < n_items) begin
			sd = $urandom_range(0, 1);
			pick = $urandom_range(0, 99);
			if (pick == 0) begin
				// snapshot; the large ones fill both sides
				snap = ($urandom_range(0, 3) == 0) ? 140 : $urandom_range(1, 30);
				send_level(1'b1, sd, near_price(sd), rand_qty());
				for (k = 1; k < snap; k++) begin
					sd = $urandom_range(0, 1);
					send_level(1'b0, sd, near_price(sd), rand_qty());
				end
				sent += snap;
			end else begin
				if (pick < 30 && book_n[sd] > 0)
					send_level(1'b0, sd, held_price(sd), rand_qty());
				else if (pick < 45 && book_n[sd] > 0)
					send_level(1'b0, sd, held_price(sd), 48'd0);
				else if (pick < 50)
					send_level(pick == 47, sd, near_price(sd), 48'd0);
				else if (pick < 55)
					send_level(1'b0, sd, plob_pkg::PRICE_W'($urandom), rand_qty());
				else
					send_level(1'b0, sd, near_price(sd), rand_qty());
				sent++;
			end
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// slow receiver
		src_idle_pct   = 17;
		sink_stall_pct = 63;
		test_basic_updates();
		test_random_traffic(320);

		// slow sender
		src_idle_pct   = 63;
		sink_stall_pct = 17;
		test_full_book();
		test_random_traffic(320);

		// back to back
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		test_random_traffic(320);

		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		// catch any stray result after the last one
		repeat (10) @(posedge clk);

		$display("sent %0d level updates, compared %0d results", level_updates, results_checked);
		$display("replaced %0d, inserted %0d, removed %0d, ignored %0d, dropped worst %0d, %s %0d",
			status_seen[plob_pkg::ST_REPLACED], status_seen[plob_pkg::ST_INSERTED],
			status_seen[plob_pkg::ST_REMOVED], status_seen[plob_pkg::ST_IGNORED],
			status_seen[plob_pkg::ST_DROPPED], "not kept",
			status_seen[plob_pkg::ST_NOT_KEPT]);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// hang guard
	initial begin
		#1_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
